[sv/minimum_window_substring_unit_assert.svh]
// Assertion helpers for the minimum window unit.
// Both macros sample on i_clk and are off while i_rst_n is low.
`ifndef MINIMUM_WINDOW_SUBSTRING_UNIT_ASSERT_SVH
`define MINIMUM_WINDOW_SUBSTRING_UNIT_ASSERT_SVH

// Property that holds on every sampled edge.
`define MWS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("mws: invariant violated");

// Antecedent on one edge, consequent on the next.
`define MWS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mws: sequence violated");

`endif

[sv/mws_pkg.sv]
package mws_pkg;

    localparam int unsigned ALPHABET    = 256;
    localparam int unsigned MAX_TEXT    = 4096;

    localparam int unsigned SYM_W       = 8;
    localparam int unsigned REQ_W       = 2;
    localparam int unsigned CNT_W       = 13;
    localparam int unsigned START_W     = 12;
    localparam int unsigned LEN_W       = 13;

    localparam int unsigned HIST_AW     = $clog2(ALPHABET);
    localparam int unsigned TS_AW       = $clog2(MAX_TEXT);
    localparam int unsigned TPOS_W      = $clog2(MAX_TEXT + 1);

    localparam logic [CNT_W-1:0] PAT_LEN_MAX = CNT_W'(8191);

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_PATTERN = 2'd1,
        REQ_TEXT    = 2'd2
    } t_req;

    // Results of the shared count/compare unit.
    typedef struct packed {
        logic [CNT_W-1:0] inc;
        logic [CNT_W-1:0] dec;
        logic             a_gt_b;
        logic             b_zero;
        logic             inc_le_b;
    } t_cnt_res;

endpackage

[sv/minimum_window_substring_unit.sv]
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// input    | i_valid / o_stall         | i_req_type, i_symbol
// output   | o_valid / i_stall         | o_found, o_best_start, o_best_len, o_overflow
//
// Clear, unused code, dropped or ignored byte: S_OUT only. Pattern byte taken:
// S_PAT_WR, then S_OUT. Text byte: S_TXT_UPD, then, once the pattern is covered,
// a start check; per byte the window start moves past, a text read, a histogram
// read and a compare/write through the one count unit; then best-window update.
// Reset (i_rst_n low, synchronous) empties both histograms at once via valid bits.
// A finished result waits in the output register; the next transfer is taken
// meanwhile, and the sequencer holds in S_OUT only if that register is still full.
`include "minimum_window_substring_unit_assert.svh"

module minimum_window_substring_unit
    import mws_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [SYM_W-1:0]   i_symbol,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_found,
    output logic [START_W-1:0] o_best_start,
    output logic [LEN_W-1:0]   o_best_len,
    output logic               o_overflow
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAT_WR,
        S_TXT_UPD,
        S_SH_CHK,
        S_SH_SYM,
        S_SH_DEC,
        S_BEST,
        S_OUT
    } t_state;

    t_state r_state;

    // window / text bookkeeping
    logic [TS_AW-1:0]   r_ws;
    logic [TPOS_W-1:0]  r_tpos;
    logic [CNT_W-1:0]   r_matched;
    logic [CNT_W-1:0]   r_plen;
    logic [TS_AW-1:0]   r_best_start;
    logic [TPOS_W-1:0]  r_best_len;
    logic               r_found;
    logic               r_overflow;
    logic [HIST_AW-1:0] r_sym;

    // memory ports
    logic [HIST_AW-1:0] hist_raddr;
    logic [CNT_W-1:0]   pat_rdata;
    logic [CNT_W-1:0]   win_rdata;
    logic               pat_we;
    logic               win_we;
    logic [CNT_W-1:0]   win_wdata;
    logic               hist_clr;
    logic               txt_we;
    logic [SYM_W-1:0]   txt_rdata;

    logic [CNT_W-1:0]   cnt_a;
    t_cnt_res           cnt_res;

    logic               accept;
    t_req               req;
    logic               in_range;
    logic               txt_full;
    logic [CNT_W-1:0]   n_matched;
    logic [TPOS_W-1:0]  win_len;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_stall  = (r_state != S_IDLE);
    assign req      = t_req'(i_req_type);
    assign in_range = ({1'b0, i_symbol} < (SYM_W + 1)'(ALPHABET));
    assign txt_full = (r_tpos >= TPOS_W'(MAX_TEXT));

    // hist address: incoming byte on accept, stored text byte during shrink
    always_comb begin
        case (r_state)
            S_IDLE:   hist_raddr = i_symbol[HIST_AW-1:0];
            S_SH_SYM: hist_raddr = txt_rdata[HIST_AW-1:0];
            default:  hist_raddr = r_sym;
        endcase
    end

    assign hist_clr  = accept && (req == REQ_CLEAR);
    assign txt_we    = accept && (req == REQ_TEXT) && in_range && !txt_full;
    assign cnt_a     = (r_state == S_PAT_WR) ? pat_rdata : win_rdata;
    assign pat_we    = (r_state == S_PAT_WR);
    // surplus byte at the start gives its count back
    assign win_we    = (r_state == S_TXT_UPD) || ((r_state == S_SH_DEC) && cnt_res.a_gt_b);
    assign win_wdata = (r_state == S_TXT_UPD) ? cnt_res.inc : cnt_res.dec;
    assign n_matched = r_matched +
                       CNT_W'(!cnt_res.b_zero && cnt_res.inc_le_b);
    assign win_len   = r_tpos - TPOS_W'(r_ws);

    mws_cnt_unit u_cnt (
        .i_a   (cnt_a),
        .i_b   (pat_rdata),
        .o_res (cnt_res)
    );

    mws_hist u_pat_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (hist_clr),
        .i_raddr (hist_raddr),
        .o_rdata (pat_rdata),
        .i_we    (pat_we),
        .i_waddr (r_sym),
        .i_wdata (cnt_res.inc)
    );

    mws_hist u_win_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (hist_clr),
        .i_raddr (hist_raddr),
        .o_rdata (win_rdata),
        .i_we    (win_we),
        .i_waddr (r_sym),
        .i_wdata (win_wdata)
    );

    mws_text u_text (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (r_tpos[TS_AW-1:0]),
        .i_wdata (i_symbol),
        .i_raddr (r_ws),
        .o_rdata (txt_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ws         <= '0;
            r_tpos       <= '0;
            r_matched    <= '0;
            r_plen       <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_found      <= 1'b0;
            r_overflow   <= 1'b0;
            r_sym        <= '0;
            o_valid      <= 1'b0;
            o_found      <= 1'b0;
            o_best_start <= '0;
            o_best_len   <= '0;
            o_overflow   <= 1'b0;
        end else begin
            // S_OUT handles the output register itself
            if (o_valid && !i_stall && (r_state != S_OUT)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sym <= i_symbol[HIST_AW-1:0];
                        case (req)
                            REQ_CLEAR: begin
                                r_ws         <= '0;
                                r_tpos       <= '0;
                                r_matched    <= '0;
                                r_plen       <= '0;
                                r_best_start <= '0;
                                r_best_len   <= '0;
                                r_found      <= 1'b0;
                                r_overflow   <= 1'b0;
                                r_state      <= S_OUT;
                            end
                            REQ_PATTERN: begin
                                // pattern is frozen once text has started
                                if (in_range && (r_tpos == '0) && (r_plen < PAT_LEN_MAX)) begin
                                    r_state <= S_PAT_WR;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            REQ_TEXT: begin
                                if (in_range && !txt_full) begin
                                    r_state <= S_TXT_UPD;
                                end else begin
                                    if (in_range) begin
                                        r_overflow <= 1'b1;
                                    end
                                    r_state <= S_OUT;
                                end
                            end
                            default: begin
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_PAT_WR: begin
                    r_plen  <= r_plen + CNT_W'(1);
                    r_state <= S_OUT;
                end
                S_TXT_UPD: begin
                    r_matched <= n_matched;
                    r_tpos    <= r_tpos + TPOS_W'(1);
                    if ((r_plen != '0) && (n_matched == r_plen)) begin
                        r_state <= S_SH_CHK;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SH_CHK: begin
                    // text read at r_ws is under way this cycle
                    if (TPOS_W'(r_ws) < r_tpos) begin
                        r_state <= S_SH_SYM;
                    end else begin
                        r_state <= S_BEST;
                    end
                end
                S_SH_SYM: begin
                    r_sym   <= txt_rdata[HIST_AW-1:0];
                    r_state <= S_SH_DEC;
                end
                S_SH_DEC: begin
                    if (cnt_res.a_gt_b || cnt_res.b_zero) begin
                        r_ws    <= r_ws + TS_AW'(1);
                        r_state <= S_SH_CHK;
                    end else begin
                        r_state <= S_BEST;
                    end
                end
                S_BEST: begin
                    if (!r_found || (win_len < r_best_len)) begin
                        r_found      <= 1'b1;
                        r_best_len   <= win_len;
                        r_best_start <= r_ws;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid      <= 1'b1;
                        o_found      <= r_found;
                        o_best_start <= START_W'(r_best_start);
                        o_best_len   <= LEN_W'(r_best_len);
                        o_overflow   <= r_overflow;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `MWS_ASSERT_ALWAYS(a_ws_in_text, TPOS_W'(r_ws) <= r_tpos)
    `MWS_ASSERT_ALWAYS(a_match_bound, r_matched <= r_plen)
    `MWS_ASSERT_ALWAYS(a_best_fits, !r_found || ((r_best_len != '0) && (r_best_len <= r_tpos)))
    `MWS_ASSERT_NEXT(a_busy_after_take, i_valid && !o_stall, o_stall)

endmodule

[sv/mws_cnt_unit.sv]
module mws_cnt_unit
    import mws_pkg::*;
(
    input  logic [CNT_W-1:0] i_a,
    input  logic [CNT_W-1:0] i_b,
    output t_cnt_res         o_res
);

    always_comb begin
        o_res.inc      = i_a + CNT_W'(1);
        o_res.dec      = i_a - CNT_W'(1);
        o_res.a_gt_b   = (i_a > i_b);
        o_res.b_zero   = (i_b == '0);
        o_res.inc_le_b = (o_res.inc <= i_b);
    end

endmodule

[sv/mws_hist.sv]
module mws_hist
    import mws_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clr,
    input  logic [HIST_AW-1:0] i_raddr,
    output logic [CNT_W-1:0]   o_rdata,
    input  logic               i_we,
    input  logic [HIST_AW-1:0] i_waddr,
    input  logic [CNT_W-1:0]   i_wdata
);

    logic [CNT_W-1:0] r_mem [ALPHABET];
    logic             r_vld [ALPHABET];

    // entry without valid bit reads as zero
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            for (int k = 0; k < ALPHABET; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

endmodule

[sv/mws_text.sv]
module mws_text
    import mws_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [TS_AW-1:0] i_waddr,
    input  logic [SYM_W-1:0] i_wdata,
    input  logic [TS_AW-1:0] i_raddr,
    output logic [SYM_W-1:0] o_rdata
);

    logic [SYM_W-1:0] r_mem [MAX_TEXT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[tb/tb_minimum_window_substring_unit.sv]
module tb_minimum_window_substring_unit;
    import mws_pkg::*;

    // Request code the block does not decode; it only reports.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // This only catches a hang.
    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    // A text byte with a window walk takes longest; be generous.
    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned RANDOM_ITEMS = 1650;
    localparam int unsigned MAX_SHOWN    = 10;
    localparam int unsigned HOLD_CYCLES  = 400;

    // One result transfer, field by field.
    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
        logic               ovf;
    } t_window_report;

    // ------------------------------------------------------------------
    // Clock, reset, block ports
    // ------------------------------------------------------------------
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic [REQ_W-1:0]   i_req_type = '0;
    logic [SYM_W-1:0]   i_symbol   = '0;
    logic               i_stall    = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic               o_found;
    logic [START_W-1:0] o_best_start;
    logic [LEN_W-1:0]   o_best_len;
    logic               o_overflow;

    always #5 i_clk = ~i_clk;

    minimum_window_substring_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_symbol     (i_symbol),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_found      (o_found),
        .o_best_start (o_best_start),
        .o_best_len   (o_best_len),
        .o_overflow   (o_overflow)
    );

    // ------------------------------------------------------------------
    // Window search predictor: its own copy of the histograms, text buffer
    // and best-window registers.
    // ------------------------------------------------------------------
    int unsigned      pat_hist [ALPHABET];
    int unsigned      win_hist [ALPHABET];
    logic [SYM_W-1:0] text_buf [MAX_TEXT];
    int unsigned      win_lo, text_len, match_cnt, pat_len;
    int unsigned      best_lo, best_span;
    bit               have_win, text_dropped;

    t_window_report   expected_reports[$];

    // Run bookkeeping
    int unsigned cycle_cnt     = 0;
    int unsigned err_cnt       = 0;
    int unsigned sent_cnt      = 0;
    int unsigned checked_cnt   = 0;
    int unsigned longest_seen  = 0;
    int unsigned overflow_seen = 0;
    bit          no_idle       = 1'b0;   // stretch with no gaps on either side
    int unsigned hold_req      = 0;      // bumped by a test to ask for a long hold-off
    int unsigned hold_ack      = 0;

    function automatic void clear_search();
        for (int i = 0; i < ALPHABET; i++) begin
            pat_hist[i] = 0;
            win_hist[i] = 0;
        end
        win_lo       = 0;
        text_len     = 0;
        match_cnt    = 0;
        pat_len      = 0;
        best_lo      = 0;
        best_span    = 0;
        have_win     = 1'b0;
        text_dropped = 1'b0;
    endfunction

    // Apply one request to the predictor and return the report it must produce.
    function automatic t_window_report predict_report(input logic [REQ_W-1:0] rt,
                                                      input logic [SYM_W-1:0] sym);
        t_window_report   rep;
        int unsigned      c;
        int unsigned      s;
        int unsigned      span;
        c = sym;
        if (rt == REQ_CLEAR) begin
            clear_search();
        end else if (c < ALPHABET) begin
            if (rt == REQ_PATTERN) begin
                // pattern is frozen once text has arrived, and capped in length
                if (text_len == 0 && pat_len < PAT_LEN_MAX) begin
                    pat_hist[c]++;
                    pat_len++;
                end
            end else if (rt == REQ_TEXT) begin
                if (text_len >= MAX_TEXT) begin
                    text_dropped = 1'b1;
                end else begin
                    text_buf[text_len] = sym;
                    win_hist[c]++;
                    if (pat_hist[c] != 0 && win_hist[c] <= pat_hist[c])
                        match_cnt++;
                    text_len++;
                    if (pat_len != 0 && match_cnt == pat_len) begin
                        // shrink from the left past surplus and unneeded bytes
                        while (win_lo < text_len &&
                               (win_hist[text_buf[win_lo]] > pat_hist[text_buf[win_lo]] ||
                                pat_hist[text_buf[win_lo]] == 0)) begin
                            s = text_buf[win_lo];
                            if (win_hist[s] > pat_hist[s])
                                win_hist[s]--;
                            win_lo++;
                        end
                        span = text_len - win_lo;
                        if (!have_win || span < best_span) begin
                            have_win  = 1'b1;
                            best_span = span;
                            best_lo   = win_lo;
                        end
                    end
                end
            end
        end
        rep.found = have_win;
        rep.start = have_win ? START_W'(best_lo)  : '0;
        rep.len   = have_win ? LEN_W'(best_span)  : '0;
        rep.ovf   = text_dropped;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Idle gaps: mostly none or short, now and then a long one.
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Symbol near a base so that patterns and text overlap; sometimes anywhere.
    function automatic logic [SYM_W-1:0] pick_symbol(input int unsigned base,
                                                     input int unsigned span);
        if ($urandom_range(0, 9) == 0)
            return SYM_W'($urandom);
        return SYM_W'(base + $urandom_range(0, span));
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transfer per call. Valid stays high across back-to-back
    // items and drops only for a gap, so each step sees one update of it.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [REQ_W-1:0] rt, input logic [SYM_W-1:0] sym);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            if (i_valid)
                i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= rt;
        i_symbol   <= sym;
        // the block takes every driven item exactly once, so predict now
        expected_reports.push_back(predict_report(rt, sym));
        do @(posedge i_clk); while (o_stall);
        sent_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls, plus a long counted hold-off on request.
    // ------------------------------------------------------------------
    initial begin : rx_stall_driver
        int unsigned n;
        forever begin
            @(posedge i_clk);
            if (hold_ack != hold_req) begin
                hold_ack = hold_req;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < 30) begin
                n = pick_gap();
                if (n == 0)
                    n = 1;
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result check: every accepted transfer against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_window_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            checked_cnt++;
            if (o_overflow === 1'b1)
                overflow_seen++;
            if (o_best_len > longest_seen)
                longest_seen = o_best_len;
            if (expected_reports.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_SHOWN)
                    $display("[%0d] unexpected result: found=%b start=%0d len=%0d ovf=%b",
                             cycle_cnt, o_found, o_best_start, o_best_len, o_overflow);
            end else begin
                want = expected_reports.pop_front();
                if (o_found !== want.found || o_best_start !== want.start ||
                    o_best_len !== want.len || o_overflow !== want.ovf) begin
                    err_cnt++;
                    if (err_cnt <= MAX_SHOWN)
                        $display("[%0d] mismatch found/start/len/ovf: exp %b/%0d/%0d/%b got %b/%0d/%0d/%b",
                                 cycle_cnt, want.found, want.start, want.len, want.ovf,
                                 o_found, o_best_start, o_best_len, o_overflow);
                end
            end
        end
    end

    // Hang guard
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every request code, and the corner cases by hand.
    task automatic test_directed_cases();
        send_item(REQ_CLEAR,   8'h00);
        send_item(REQ_UNUSED,  8'hFF);   // unused code only reports
        send_item(REQ_PATTERN, 8'h00);
        send_item(REQ_PATTERN, 8'hFF);
        send_item(REQ_PATTERN, 8'h00);   // multiplicity two
        send_item(REQ_TEXT,    8'hAA);   // not in pattern
        send_item(REQ_TEXT,    8'h00);
        send_item(REQ_TEXT,    8'h55);
        send_item(REQ_TEXT,    8'hFF);
        send_item(REQ_TEXT,    8'h00);   // first covering window
        send_item(REQ_PATTERN, 8'h12);   // ignored once text has started
        send_item(REQ_TEXT,    8'h00);   // surplus, start moves
        send_item(REQ_TEXT,    8'hFF);   // window just as long, earlier best kept
        send_item(REQ_UNUSED,  8'h00);
        send_item(REQ_CLEAR,   8'hFF);   // back to all zeros
        send_item(REQ_TEXT,    8'h7F);   // empty pattern: never found
        send_item(REQ_TEXT,    8'h80);
        send_item(REQ_TEXT,    8'h7F);
        send_item(REQ_PATTERN, 8'h01);   // ignored, text present
        send_item(REQ_CLEAR,   8'h00);
        send_item(REQ_PATTERN, 8'h5A);
        send_item(REQ_TEXT,    8'h5A);   // one-byte window
        send_item(REQ_TEXT,    8'h5A);
    endtask

    // Receiver holds off while the sender keeps offering: the block must fill
    // up, stall its input, and lose nothing.
    task automatic test_output_backpressure();
        send_item(REQ_CLEAR,   8'h00);
        send_item(REQ_PATTERN, 8'h61);
        send_item(REQ_PATTERN, 8'h62);
        no_idle = 1'b1;
        hold_req++;
        repeat (40) send_item(REQ_TEXT, pick_symbol(8'h60, 3));
        no_idle = 1'b0;
    endtask

    // Mostly well-formed sessions (clear, pattern, text) with random content,
    // the rest noise: unused codes, late pattern bytes, random request mixes.
    task automatic test_random_sessions();
        int unsigned applied;
        int unsigned plen;
        int unsigned tlen;
        int unsigned base;
        int unsigned span;
        int unsigned r;
        logic [REQ_W-1:0] rt;
        applied = 0;
        while (applied < RANDOM_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 99) < 85) begin
                base = $urandom_range(0, 255);
                span = $urandom_range(1, 7);
                send_item(REQ_CLEAR, SYM_W'($urandom));
                plen = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
                repeat (plen) send_item(REQ_PATTERN, pick_symbol(base, span));
                tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 50);
                repeat (tlen) begin
                    r = $urandom_range(0, 39);
                    if (r == 0)
                        send_item(REQ_UNUSED, SYM_W'($urandom));
                    else if (r == 1)
                        send_item(REQ_PATTERN, pick_symbol(base, span));
                    send_item(REQ_TEXT, pick_symbol(base, span));
                end
                applied += 1 + plen + tlen;
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    rt = REQ_W'($urandom_range(0, 3));
                    send_item(rt, SYM_W'($urandom));
                    if (rt != REQ_UNUSED)
                        applied++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_search();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_output_backpressure();
        test_random_sessions();

        // drain: wait for every report, then a quiet tail for strays
        i_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d transfers in, %0d reports checked, %0d mismatches",
                 sent_cnt, checked_cnt, err_cnt);
        $display("run: longest best window %0d, %0d reports with overflow set",
                 longest_seen, overflow_seen);
        if (err_cnt == 0 && expected_reports.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[minimum_window_substring_unit.f]
+incdir+sv
sv/mws_pkg.sv
sv/mws_cnt_unit.sv
sv/mws_hist.sv
sv/mws_text.sv
sv/minimum_window_substring_unit.sv
tb/tb_minimum_window_substring_unit.sv
